FILE: hdl/prla_pkg.sv
// ----------------------------------------------------------------------------
// Paired resource lock arbiter package
// Shared codes for the arbiter: sequencer states, request types, arbitration
// modes and configuration register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package prla_pkg;

    // Sequencer states.
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_READ_L = 2'd1;
    localparam logic [1:0] ST_CALC   = 2'd2;
    localparam logic [1:0] ST_WRITE  = 2'd3;

    // Request types.
    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Arbitration modes.
    localparam logic MODE_CLAIM  = 1'b0;
    localparam logic MODE_TICKET = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_ARB_MODE  = 1'b0;
    localparam logic CFG_RING_SIZE = 1'b1;

    // Configuration field widths and reset values.
    localparam int unsigned RING_W = 5;
    localparam logic [RING_W-1:0] RING_RESET = 5'd5;
    localparam logic [RING_W-1:0] RING_MIN   = 5'd2;

endpackage

FILE: hdl/paired_resource_lock_arbiter_unit.sv
// ----------------------------------------------------------------------------
// Paired resource lock arbiter unit
// Arbitrates a ring of shared resources in which each requester must take its
// own resource and the next one around the ring together, by claims or by
// turn passing, with the per-resource state held in a synchronous memory.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. An acquire or a
// release with a valid requester steps through the sequencer states: its own
// resource entry is read in the accept cycle, the next one in the read state,
// the first entry is rewritten in the calculate state and the second in the
// write state, during which o_done pulses with the result; busy is high from
// the read state to the write state. The single read port and single write
// port of the state memory set this sequence. A request whose requester is
// not below the ring size is answered in the next cycle, with only
// o_bad_request set, and busy does not rise for it. Results are shown for
// exactly one cycle and cannot be held off, so the receiver must take each
// o_done pulse as it comes. Configuration may be written at any time the unit
// is idle. Resource entries read as free with no holder after reset without a
// clearing pass: a flip-flop per entry marks whether it has been written.
// ----------------------------------------------------------------------------
module paired_resource_lock_arbiter_unit #(
    parameter int unsigned MAX_SEATS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Request channel.
    input  logic       start,
    output logic       busy,
    input  logic       i_req_type,
    input  logic [3:0] i_requester,
    // Result channel.
    output logic       o_done,
    output logic       o_granted,
    output logic       o_right_claim_set,
    output logic       o_left_claim_set,
    output logic       o_bad_request,
    // Configuration write port.
    input  logic       i_cfg_we,
    input  logic       i_cfg_addr,
    input  logic [4:0] i_cfg_wdata
);

    // Address width of the state memory, and width of a stored holder id,
    // which must hold any requester index and any resource index.
    localparam int unsigned AW  = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
    localparam int unsigned IDW = (AW > 4) ? AW : 4;
    localparam int unsigned RW  = prla_pkg::RING_W;

    typedef struct packed {
        logic           busy;
        logic           vld;
        logic [IDW-1:0] id;
    } t_entry;

    // ------------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------------
    logic          r_mode;
    logic [RW-1:0] r_ring;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= prla_pkg::MODE_CLAIM;
            r_ring <= prla_pkg::RING_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                prla_pkg::CFG_ARB_MODE:  r_mode <= i_cfg_wdata[0];
                prla_pkg::CFG_RING_SIZE: r_ring <= i_cfg_wdata;
            endcase
        end
    end

    // The ring size in effect is clamped to the range that the hardware has.
    // The upper clamp only applies when MAX_SEATS is below the register range,
    // so the constant always fits the register width.
    logic [RW-1:0] ring_eff;

    always_comb begin
        if (r_ring < prla_pkg::RING_MIN) begin
            ring_eff = prla_pkg::RING_MIN;
        end else if (32'(r_ring) > MAX_SEATS) begin
            ring_eff = RW'(MAX_SEATS);
        end else begin
            ring_eff = r_ring;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer and transaction registers.
    // ------------------------------------------------------------------------
    logic [1:0]    r_state;
    logic [1:0]    n_state;
    logic          r_rel;
    logic [3:0]    r_who;
    logic [AW-1:0] r_ra;
    logic [AW-1:0] r_la;
    t_entry        r_ent_r;
    t_entry        r_new_l;

    logic          r_done;
    logic          r_granted;
    logic          r_rc;
    logic          r_lc;
    logic          r_bad;

    logic          accept;
    logic          bad_req;
    logic [RW-1:0] who_ext;
    logic [RW-1:0] who_inc;
    logic [RW-1:0] left_idx;

    assign accept   = start && (r_state == prla_pkg::ST_IDLE);
    assign who_ext  = RW'(i_requester);
    assign bad_req  = (who_ext >= ring_eff);
    assign who_inc  = who_ext + RW'(1);
    assign left_idx = (who_inc == ring_eff) ? '0 : who_inc;

    // ------------------------------------------------------------------------
    // State memory: one read port with registered data, one write port.
    // r_written marks entries that hold real data; others read as reset.
    // ------------------------------------------------------------------------
    t_entry                 mem [MAX_SEATS];
    logic [MAX_SEATS-1:0]   r_written;
    logic [AW-1:0]          rd_addr;
    t_entry                 r_rd_data;
    logic                   r_rd_ok;
    t_entry                 rd_eff;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    t_entry                 wr_data;

    assign rd_addr = (r_state == prla_pkg::ST_IDLE) ? AW'(i_requester) : r_la;

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[rd_addr];
        r_rd_ok   <= r_written[rd_addr];
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (wr_en) begin
            r_written[wr_addr] <= 1'b1;
        end
    end

    assign rd_eff = r_rd_ok ? r_rd_data : '0;

    // ------------------------------------------------------------------------
    // Arbitration on the two entries. In the calculate state r_ent_r holds the
    // requester's own resource and the read port delivers the next resource.
    // ------------------------------------------------------------------------
    t_entry         er;
    t_entry         el;
    t_entry         new_r;
    t_entry         new_l;
    logic           grant;
    logic           rc;
    logic           lc;
    logic           blk_r;
    logic           blk_l;
    logic [IDW-1:0] who_id;
    logic [IDW-1:0] prev_id;
    logic [RW-1:0]  ring_last;

    assign who_id    = IDW'(r_who);
    assign ring_last = ring_eff - RW'(1);
    assign prev_id   = (r_ra == '0) ? IDW'(ring_last) : IDW'(r_ra) - IDW'(1);

    always_comb begin
        er    = r_ent_r;
        el    = rd_eff;
        new_r = er;
        new_l = el;
        grant = 1'b0;
        rc    = 1'b0;
        lc    = 1'b0;
        blk_r = 1'b0;
        blk_l = 1'b0;
        if (r_mode == prla_pkg::MODE_TICKET) begin
            if (r_rel == prla_pkg::REQ_RELEASE) begin
                // Turns pass to the neighbors on each side.
                new_r.vld = 1'b1;
                new_r.id  = prev_id;
                new_l.vld = 1'b1;
                new_l.id  = IDW'(r_la);
            end else begin
                blk_r = er.vld && (er.id != who_id);
                blk_l = el.vld && (el.id != who_id);
                if (!blk_r && !blk_l) begin
                    // The winner keeps both turns so a neighbor cannot also win.
                    grant     = 1'b1;
                    new_r.vld = 1'b1;
                    new_r.id  = who_id;
                    new_l.vld = 1'b1;
                    new_l.id  = who_id;
                end
            end
        end else begin
            if (r_rel == prla_pkg::REQ_RELEASE) begin
                // Claims survive a release; only the busy flags drop.
                new_r.busy = 1'b0;
                new_l.busy = 1'b0;
            end else begin
                rc    = er.busy;
                lc    = el.busy;
                blk_r = er.busy || (er.vld && (er.id != who_id));
                blk_l = el.busy || (el.vld && (el.id != who_id));
                if (er.busy) begin
                    new_r.vld = 1'b1;
                    new_r.id  = who_id;
                end
                if (el.busy) begin
                    new_l.vld = 1'b1;
                    new_l.id  = who_id;
                end
                if (!blk_r && !blk_l) begin
                    grant = 1'b1;
                    new_r = '{busy: 1'b1, vld: 1'b0, id: '0};
                    new_l = '{busy: 1'b1, vld: 1'b0, id: '0};
                end
            end
        end
    end

    // Write port: own entry in the calculate state, next entry in the last.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_ra;
        wr_data = new_r;
        unique case (r_state)
            prla_pkg::ST_CALC: begin
                wr_en = 1'b1;
            end
            prla_pkg::ST_WRITE: begin
                wr_en   = 1'b1;
                wr_addr = r_la;
                wr_data = r_new_l;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prla_pkg::ST_IDLE:   if (accept && !bad_req) n_state = prla_pkg::ST_READ_L;
            prla_pkg::ST_READ_L: n_state = prla_pkg::ST_CALC;
            prla_pkg::ST_CALC:   n_state = prla_pkg::ST_WRITE;
            prla_pkg::ST_WRITE:  n_state = prla_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prla_pkg::ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (accept && bad_req) || (r_state == prla_pkg::ST_CALC);
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rel     <= i_req_type;
            r_who     <= i_requester;
            r_ra      <= AW'(i_requester);
            r_la      <= AW'(left_idx);
            r_granted <= 1'b0;
            r_rc      <= 1'b0;
            r_lc      <= 1'b0;
            r_bad     <= bad_req;
        end
        if (r_state == prla_pkg::ST_READ_L) begin
            r_ent_r <= rd_eff;
        end
        if (r_state == prla_pkg::ST_CALC) begin
            r_new_l   <= new_l;
            r_granted <= grant;
            r_rc      <= rc;
            r_lc      <= lc;
        end
    end

    assign busy              = (r_state != prla_pkg::ST_IDLE);
    assign o_done            = r_done;
    assign o_granted         = r_granted;
    assign o_right_claim_set = r_rc;
    assign o_left_claim_set  = r_lc;
    assign o_bad_request     = r_bad;

endmodule

FILE: dv/paired_resource_lock_arbiter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Paired resource lock arbiter unit test
// Drives acquire and release transactions into the arbiter under both
// arbitration modes and a range of ring sizes, predicts every answer with a
// local model of the resource ring, and compares each o_done pulse with it.
// ----------------------------------------------------------------------------
module paired_resource_lock_arbiter_unit_test;

    localparam int unsigned SEATS       = 16;
    // Cycles with no transaction of any kind before the run is declared hung.
    // The longest legal quiet stretch is a sender gap (capped at MAX_GAP)
    // or the drain before a configuration write, both far below this.
    localparam int unsigned STALL_LIMIT = 500;
    localparam int unsigned MAX_GAP     = 16;
    localparam int unsigned DRAIN_WAIT  = 4;
    localparam int unsigned ITEMS_EACH  = 95;

    // One answer of the arbiter, as seen on the result ports.
    typedef struct packed {
        logic granted;
        logic right_claim;
        logic left_claim;
        logic bad_request;
    } t_arb_outcome;

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the unit. Every input starts at a known
    // value so nothing is undefined while reset is held.
    // ------------------------------------------------------------------------
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic       busy;
    logic       i_req_type  = prla_pkg::REQ_ACQUIRE;
    logic [3:0] i_requester = 4'd0;
    logic       o_done;
    logic       o_granted;
    logic       o_right_claim_set;
    logic       o_left_claim_set;
    logic       o_bad_request;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_addr  = prla_pkg::CFG_ARB_MODE;
    logic [4:0] i_cfg_wdata = 5'd0;

    paired_resource_lock_arbiter_unit #(
        .MAX_SEATS(SEATS)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_req_type        (i_req_type),
        .i_requester       (i_requester),
        .o_done            (o_done),
        .o_granted         (o_granted),
        .o_right_claim_set (o_right_claim_set),
        .o_left_claim_set  (o_left_claim_set),
        .o_bad_request     (o_bad_request),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_addr        (i_cfg_addr),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Local copy of the arbiter state. The two modes share the owner_* arrays:
    // in claim mode owner_* is the pending claimant of a resource, in
    // ticket mode it is the requester whose turn it is.
    // ------------------------------------------------------------------------
    logic              in_use      [SEATS];
    logic              owner_valid [SEATS];
    logic [3:0]        owner_id    [SEATS];
    logic              mode_reg;
    logic [4:0]        ring_reg;

    // Requesters believed to hold their two resources; used to steer most
    // releases toward real holders so the ring does not simply clog up.
    logic [SEATS-1:0]  seated_mask;

    t_arb_outcome      pending_outcomes[$];
    int unsigned       mismatch_count = 0;
    int unsigned       stall_cycles   = 0;
    int unsigned       gap_pct        = 0;

    // The ring size register is taken as is, but the unit works with it
    // clamped to the range that makes sense for the hardware.
    function automatic int unsigned ring_in_use();
        if (ring_reg < prla_pkg::RING_MIN) begin
            return 32'(prla_pkg::RING_MIN);
        end
        if (32'(ring_reg) > SEATS) begin
            return SEATS;
        end
        return 32'(ring_reg);
    endfunction

    // Claim-mode look at one resource. A busy resource takes the asker's
    // claim and blocks; a free one blocks only when someone else claimed it.
    function automatic logic claim_blocks(int unsigned idx, logic [3:0] who,
                                          output logic claimed);
        claimed = 1'b0;
        if (in_use[idx]) begin
            owner_valid[idx] = 1'b1;
            owner_id[idx]    = who;
            claimed          = 1'b1;
            return 1'b1;
        end
        return owner_valid[idx] && owner_id[idx] != who;
    endfunction

    // Works out the answer to one accepted transaction and advances the
    // local state exactly as the unit is expected to.
    function automatic t_arb_outcome resolve_request(logic kind, logic [3:0] who);
        t_arb_outcome res;
        int unsigned  n;
        int unsigned  r;
        int unsigned  l;
        logic         blocked;
        logic         l_blocked;
        res = '0;
        n   = ring_in_use();
        if (32'(who) >= n) begin
            res.bad_request = 1'b1;
            return res;
        end
        r = 32'(who);
        l = (r + 1 == n) ? 0 : r + 1;
        if (mode_reg == prla_pkg::MODE_TICKET) begin
            if (kind == prla_pkg::REQ_RELEASE) begin
                // Hand the own resource back to the neighbor below and the
                // next resource to the neighbor above.
                owner_valid[r] = 1'b1;
                owner_id[r]    = (r != 0) ? 4'(r - 1) : 4'(n - 1);
                owner_valid[l] = 1'b1;
                owner_id[l]    = 4'(l);
            end else if ((!owner_valid[r] || owner_id[r] == who) &&
                         (!owner_valid[l] || owner_id[l] == who)) begin
                // A grant takes both turns, so an adjacent requester cannot
                // also win while the turns are still unset.
                res.granted    = 1'b1;
                owner_valid[r] = 1'b1;
                owner_id[r]    = who;
                owner_valid[l] = 1'b1;
                owner_id[l]    = who;
            end
        end else begin
            if (kind == prla_pkg::REQ_RELEASE) begin
                // Claims survive a release; only the busy flags drop.
                in_use[r] = 1'b0;
                in_use[l] = 1'b0;
            end else begin
                blocked   = claim_blocks(r, who, res.right_claim);
                l_blocked = claim_blocks(l, who, res.left_claim);
                if (!blocked && !l_blocked) begin
                    in_use[r]      = 1'b1;
                    in_use[l]      = 1'b1;
                    owner_valid[r] = 1'b0;
                    owner_valid[l] = 1'b0;
                    owner_id[r]    = 4'd0;
                    owner_id[l]    = 4'd0;
                    res.granted    = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Sender side. start is only ever changed once per clock edge: after an
    // acceptance it either stays high for the next transaction or drops for
    // a gap, never both.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic kind, input logic [3:0] who);
        t_arb_outcome res;
        int unsigned  gap;
        gap = 0;
        while (gap_pct != 0 && gap < MAX_GAP && $urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            gap++;
        end
        start       <= 1'b1;
        i_req_type  <= kind;
        i_requester <= who;
        do begin
            @(posedge i_clk);
        end while (busy);
        res = resolve_request(kind, who);
        pending_outcomes.push_back(res);
        if (res.granted) begin
            seated_mask[who] = 1'b1;
        end else if (kind == prla_pkg::REQ_RELEASE && !res.bad_request) begin
            seated_mask[who] = 1'b0;
        end
    endtask

    // Configuration is only written once the unit is idle: every answer in
    // and a few more cycles for the pipeline to empty.
    task automatic write_config(input logic addr, input logic [4:0] data);
        start <= 1'b0;
        while (pending_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        if (addr == prla_pkg::CFG_ARB_MODE) begin
            mode_reg = data[0];
        end else begin
            ring_reg = data;
        end
        i_cfg_we <= 1'b0;
    endtask

    // Mostly acquires and releases by requesters inside the ring, with
    // releases usually coming from a real holder; the rest is noise with any
    // requester index, out-of-ring ones included.
    task automatic send_random_request();
        logic        kind;
        logic [3:0]  who;
        int unsigned n;
        int unsigned tries;
        n    = ring_in_use();
        kind = ($urandom_range(0, 99) < 40) ? prla_pkg::REQ_RELEASE : prla_pkg::REQ_ACQUIRE;
        who  = 4'($urandom_range(0, n - 1));
        if (kind == prla_pkg::REQ_RELEASE && $urandom_range(0, 99) < 80) begin
            tries = 0;
            while (!seated_mask[who] && tries < 8) begin
                who = 4'($urandom_range(0, n - 1));
                tries++;
            end
        end
        if ($urandom_range(0, 99) < 12) begin
            who = 4'($urandom_range(0, 15));
        end
        send_request(kind, who);
    endtask

    // One stretch of random traffic under a fixed configuration. The mode
    // register gets random upper data bits, which the unit must ignore.
    task automatic run_setting(input logic mode, input logic [4:0] ring);
        write_config(prla_pkg::CFG_ARB_MODE, {4'($urandom_range(0, 15)), mode});
        write_config(prla_pkg::CFG_RING_SIZE, ring);
        repeat (ITEMS_EACH) send_random_request();
    endtask

    // ------------------------------------------------------------------------
    // Result checking. Each o_done pulse is a transaction that cannot be held
    // off, so it is compared with the oldest expectation on the spot.
    // ------------------------------------------------------------------------
    task automatic check_field(input string field, input logic want, input logic got);
        if (want !== got) begin
            $display("%0t: %s expected %0b, got %0b", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_arb_outcome want;
        if (i_rst_n && o_done) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0b%0b%0b%0b",
                         $time, o_granted, o_right_claim_set, o_left_claim_set,
                         o_bad_request);
                mismatch_count++;
            end else begin
                want = pending_outcomes.pop_front();
                check_field("granted", want.granted, o_granted);
                check_field("right_claim_set", want.right_claim, o_right_claim_set);
                check_field("left_claim_set", want.left_claim, o_left_claim_set);
                check_field("bad_request", want.bad_request, o_bad_request);
            end
        end
    end

    // Watchdog: any accepted request, result or register write counts as
    // progress; a long run of cycles with none of them means the unit hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || i_cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
        end
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Claim mode with the reset configuration (ring of five): a grant, claims
    // on busy resources from both sides, claims that outlive a release and
    // block a later grant, a release by a requester holding nothing, and
    // requesters outside the ring.
    task automatic test_claim_basics();
        send_request(prla_pkg::REQ_ACQUIRE, 4'd0);
        send_request(prla_pkg::REQ_ACQUIRE, 4'd1);
        send_request(prla_pkg::REQ_ACQUIRE, 4'd4);
        send_request(prla_pkg::REQ_RELEASE, 4'd0);
        send_request(prla_pkg::REQ_ACQUIRE, 4'd0);
        send_request(prla_pkg::REQ_ACQUIRE, 4'd1);
        send_request(prla_pkg::REQ_RELEASE, 4'd3);
        send_request(prla_pkg::REQ_ACQUIRE, 4'd5);
        send_request(prla_pkg::REQ_ACQUIRE, 4'd15);
        send_request(prla_pkg::REQ_RELEASE, 4'd15);
    endtask

    // Ticket mode on the state left by claim mode: a grant takes both turns,
    // the neighbor is refused, a release passes the turns on (including the
    // wrap from resource zero to the top of the ring).
    task automatic test_ticket_basics();
        write_config(prla_pkg::CFG_ARB_MODE, {4'd0, prla_pkg::MODE_TICKET});
        send_request(prla_pkg::REQ_ACQUIRE, 4'd3);
        send_request(prla_pkg::REQ_ACQUIRE, 4'd4);
        send_request(prla_pkg::REQ_RELEASE, 4'd3);
        send_request(prla_pkg::REQ_ACQUIRE, 4'd4);
        send_request(prla_pkg::REQ_RELEASE, 4'd0);
        send_request(prla_pkg::REQ_ACQUIRE, 4'd2);
    endtask

    // Ring sizes below the minimum and above the seat count are clamped, and
    // the wrap from the last requester back to resource zero is exercised at
    // both ends.
    task automatic test_ring_size_limits();
        write_config(prla_pkg::CFG_RING_SIZE, 5'd0);
        send_request(prla_pkg::REQ_ACQUIRE, 4'd1);
        send_request(prla_pkg::REQ_RELEASE, 4'd1);
        send_request(prla_pkg::REQ_ACQUIRE, 4'd2);
        write_config(prla_pkg::CFG_RING_SIZE, 5'd31);
        write_config(prla_pkg::CFG_ARB_MODE, {4'hf, prla_pkg::MODE_CLAIM});
        send_request(prla_pkg::REQ_ACQUIRE, 4'd15);
        send_request(prla_pkg::REQ_ACQUIRE, 4'd0);
        send_request(prla_pkg::REQ_RELEASE, 4'd15);
        write_config(prla_pkg::CFG_RING_SIZE, 5'd1);
        send_request(prla_pkg::REQ_ACQUIRE, 4'd0);
        write_config(prla_pkg::CFG_RING_SIZE, 5'd16);
        send_request(prla_pkg::REQ_ACQUIRE, 4'd14);
    endtask

    // Random traffic with short, occasional sender gaps.
    task automatic test_traffic_light_gaps();
        gap_pct = 20;
        run_setting(prla_pkg::MODE_CLAIM, 5'd16);
        run_setting(prla_pkg::MODE_TICKET, 5'd16);
        run_setting(prla_pkg::MODE_CLAIM, 5'd3);
    endtask

    // Random traffic where the sender is mostly quiet, so gaps land on every
    // cycle of the unit's sequence.
    task automatic test_traffic_heavy_gaps();
        gap_pct = 75;
        run_setting(prla_pkg::MODE_TICKET, 5'd0);
        run_setting(prla_pkg::MODE_CLAIM, 5'd31);
        run_setting(prla_pkg::MODE_TICKET, 5'd9);
    endtask

    // Random traffic back to back, start held high between configuration writes.
    task automatic test_traffic_back_to_back();
        gap_pct = 0;
        run_setting(prla_pkg::MODE_CLAIM, 5'd1);
        run_setting(prla_pkg::MODE_TICKET, 5'd5);
        run_setting(prla_pkg::MODE_CLAIM, 5'd12);
    endtask

    initial begin
        for (int i = 0; i < SEATS; i++) begin
            in_use[i]      = 1'b0;
            owner_valid[i] = 1'b0;
            owner_id[i]    = 4'd0;
        end
        mode_reg    = prla_pkg::MODE_CLAIM;
        ring_reg    = prla_pkg::RING_RESET;
        seated_mask = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_claim_basics();
        test_ticket_basics();
        test_ring_size_limits();
        test_traffic_light_gaps();
        test_traffic_heavy_gaps();
        test_traffic_back_to_back();

        // Let the last answers arrive, then keep the clock running so a stray
        // extra pulse would still be caught.
        start <= 1'b0;
        while (pending_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/prla_pkg.sv
hdl/paired_resource_lock_arbiter_unit.sv
dv/paired_resource_lock_arbiter_unit_test.sv
